FILE: rtl/eet_pkg.sv
// ============================================================================
// eet_pkg: shared types and constants of the extreme event tracker
// Widths, default parameter values, the result beat layout and the
// sequencer state codes of the tracker's back part.
// ============================================================================
`default_nettype none

package eet_pkg;

  // Width of the event size field on the input channel (unsigned Q16.16).
  localparam int EventW = 32;

  // Defaults for the top level parameters.
  localparam int DefSetSize   = 8;
  localparam int DefValueBits = 32;

  // One result beat.
  typedef struct packed {
    logic is_extreme;
    logic small_hit;
    logic large_hit;
    logic rejected;
  } eet_result_t;

  // Back part sequencer, one-hot.
  typedef enum logic [2:0] {
    S_IDLE   = 3'b001,
    S_SCAN   = 3'b010,
    S_UPDATE = 3'b100
  } eet_state_e;

endpackage

`default_nettype wire

FILE: rtl/eet_if.sv
// ============================================================================
// eet_if: valid/ready channels of the extreme event tracker
// The event channel carries one size per beat; the result channel carries
// the hit flags of one event per beat.
// ============================================================================
`default_nettype none

interface eet_evt_if;
  import eet_pkg::*;

  logic              valid;
  logic              ready;
  logic [EventW-1:0] event_size;

  modport source (output valid, output event_size, input ready);
  modport sink   (input valid, input event_size, output ready);
endinterface

interface eet_res_if;
  logic valid;
  logic ready;
  logic is_extreme;
  logic small_hit;
  logic large_hit;
  logic rejected;

  modport source (output valid, output is_extreme, output small_hit,
                  output large_hit, output rejected, input ready);
  modport sink   (input valid, input is_extreme, input small_hit,
                  input large_hit, input rejected, output ready);
endinterface

`default_nettype wire

FILE: rtl/eet_front.sv
// ============================================================================
// eet_front: event intake and classification
// Accepts event beats, trims them to the value width, flags zero sizes and
// holds them in a two-entry queue for the back part.
// ============================================================================
`default_nettype none

module eet_front #(
  parameter int VALUE_BITS = eet_pkg::DefValueBits
) (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  eet_evt_if.sink              evt_i,
  output logic                 deq_valid_o,
  input  wire                  deq_ready_i,
  output logic [VALUE_BITS-1:0] deq_value_o,
  output logic                 deq_rejected_o
);
  import eet_pkg::*;

  localparam int WideW = VALUE_BITS + EventW;

  logic [WideW-1:0]      wide;
  logic [VALUE_BITS-1:0] value;
  logic                  push;
  logic                  pop;

  logic [VALUE_BITS-1:0] val_q [2];
  logic [1:0]            rej_q;
  logic                  wr_ptr_q, wr_ptr_d;
  logic                  rd_ptr_q, rd_ptr_d;
  logic [1:0]            cnt_q, cnt_d;

  // Bits above the value width are dropped before the zero test.
  assign wide  = {{VALUE_BITS{1'b0}}, evt_i.event_size};
  assign value = wide[VALUE_BITS-1:0];

  assign evt_i.ready = (cnt_q != 2'd2);
  assign push        = evt_i.valid && evt_i.ready;
  assign pop         = deq_valid_o && deq_ready_i;

  assign deq_valid_o    = (cnt_q != 2'd0);
  assign deq_value_o    = val_q[rd_ptr_q];
  assign deq_rejected_o = rej_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? ~rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q;
    if (push && !pop) begin
      cnt_d = cnt_q + 2'd1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      val_q[wr_ptr_q] <= value;
      rej_q[wr_ptr_q] <= (value == '0);
    end
  end

endmodule

`default_nettype wire

FILE: rtl/eet_back.sv
// ============================================================================
// eet_back: set scan and replacement
// Scans both sets one slot per cycle to find the victims, then replaces
// them when the event qualifies and issues the result beat; rejected events skip the scan.
// ============================================================================
`default_nettype none

module eet_back #(
  parameter int SET_SIZE   = eet_pkg::DefSetSize,
  parameter int VALUE_BITS = eet_pkg::DefValueBits
) (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  input  wire                   deq_valid_i,
  output logic                  deq_ready_o,
  input  wire  [VALUE_BITS-1:0] deq_value_i,
  input  wire                   deq_rejected_i,
  eet_res_if.source             res_o
);
  import eet_pkg::*;

  localparam int IdxW = (SET_SIZE > 1) ? $clog2(SET_SIZE) : 1;
  localparam logic [IdxW-1:0] LastIdx = IdxW'(SET_SIZE - 1);

  eet_state_e state_q, state_d;

  logic [VALUE_BITS-1:0] ev_q, ev_d;
  logic                  rej_q, rej_d;
  logic [IdxW-1:0]       cnt_q, cnt_d;
  logic                  proc_vld_q, proc_vld_d;
  logic [IdxW-1:0]       proc_idx_q, proc_idx_d;

  logic                  s_free_q, s_free_d;
  logic [IdxW-1:0]       s_vic_q, s_vic_d;
  logic [VALUE_BITS-1:0] s_best_q, s_best_d;
  logic                  l_free_q, l_free_d;
  logic [IdxW-1:0]       l_vic_q, l_vic_d;
  logic [VALUE_BITS-1:0] l_best_q, l_best_d;

  logic [SET_SIZE-1:0]   s_used_q, s_used_d;
  logic [SET_SIZE-1:0]   l_used_q, l_used_d;

  logic [VALUE_BITS-1:0] small_mem_q [SET_SIZE];
  logic [VALUE_BITS-1:0] large_mem_q [SET_SIZE];
  logic [VALUE_BITS-1:0] small_rd_q;
  logic [VALUE_BITS-1:0] large_rd_q;

  eet_result_t           res_q, res_d;
  logic                  res_vld_q, res_vld_d;

  logic                  s_used_rd, l_used_rd, first;
  logic                  s_hit, l_hit, fire, s_we, l_we;

  assign s_used_rd = s_used_q[proc_idx_q];
  assign l_used_rd = l_used_q[proc_idx_q];
  assign first     = (proc_idx_q == '0);

  // Strict compares: an event equal to the victim leaves the set alone.
  assign s_hit = !rej_q && (s_free_q || (ev_q < s_best_q));
  assign l_hit = !rej_q && (l_free_q || (ev_q > l_best_q));
  assign fire  = (state_q == S_UPDATE) && (!res_vld_q || res_o.ready);
  assign s_we  = fire && s_hit;
  assign l_we  = fire && l_hit;

  assign deq_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d    = state_q;
    ev_d       = ev_q;
    rej_d      = rej_q;
    cnt_d      = cnt_q;
    proc_vld_d = proc_vld_q;
    proc_idx_d = proc_idx_q;
    s_free_d   = s_free_q;
    s_vic_d    = s_vic_q;
    s_best_d   = s_best_q;
    l_free_d   = l_free_q;
    l_vic_d    = l_vic_q;
    l_best_d   = l_best_q;
    s_used_d   = s_used_q;
    l_used_d   = l_used_q;
    res_d      = res_q;
    res_vld_d  = res_vld_q && !res_o.ready;

    unique case (state_q)
      S_IDLE: begin
        if (deq_valid_i) begin
          ev_d       = deq_value_i;
          rej_d      = deq_rejected_i;
          cnt_d      = '0;
          proc_vld_d = 1'b0;
          s_free_d   = 1'b0;
          l_free_d   = 1'b0;
          state_d    = deq_rejected_i ? S_UPDATE : S_SCAN;
        end
      end
      S_SCAN: begin
        // Issue the read of slot cnt_q; the slot read last cycle is judged now.
        proc_vld_d = 1'b1;
        proc_idx_d = cnt_q;
        cnt_d      = (cnt_q == LastIdx) ? cnt_q : cnt_q + 1'b1;
        if (proc_vld_q) begin
          if (!s_free_q) begin
            if (!s_used_rd) begin
              s_free_d = 1'b1;
              s_vic_d  = proc_idx_q;
            end else if (first || (small_rd_q > s_best_q)) begin
              s_vic_d  = proc_idx_q;
              s_best_d = small_rd_q;
            end
          end
          if (!l_free_q) begin
            if (!l_used_rd) begin
              l_free_d = 1'b1;
              l_vic_d  = proc_idx_q;
            end else if (first || (large_rd_q < l_best_q)) begin
              l_vic_d  = proc_idx_q;
              l_best_d = large_rd_q;
            end
          end
          if (proc_idx_q == LastIdx) begin
            proc_vld_d = 1'b0;
            state_d    = S_UPDATE;
          end
        end
      end
      S_UPDATE: begin
        if (fire) begin
          if (s_we) begin
            s_used_d[s_vic_q] = 1'b1;
          end
          if (l_we) begin
            l_used_d[l_vic_q] = 1'b1;
          end
          res_d.is_extreme = s_hit || l_hit;
          res_d.small_hit  = s_hit;
          res_d.large_hit  = l_hit;
          res_d.rejected   = rej_q;
          res_vld_d        = 1'b1;
          state_d          = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      proc_vld_q <= 1'b0;
      s_used_q   <= '0;
      l_used_q   <= '0;
      res_vld_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      proc_vld_q <= proc_vld_d;
      s_used_q   <= s_used_d;
      l_used_q   <= l_used_d;
      res_vld_q  <= res_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ev_q       <= ev_d;
    rej_q      <= rej_d;
    cnt_q      <= cnt_d;
    proc_idx_q <= proc_idx_d;
    s_free_q   <= s_free_d;
    s_vic_q    <= s_vic_d;
    s_best_q   <= s_best_d;
    l_free_q   <= l_free_d;
    l_vic_q    <= l_vic_d;
    l_best_q   <= l_best_d;
    res_q      <= res_d;
  end

  // Value stores: one write and one registered read port each.
  always_ff @(posedge clk_i) begin
    if (s_we) begin
      small_mem_q[s_vic_q] <= ev_q;
    end
    small_rd_q <= small_mem_q[cnt_q];
  end

  always_ff @(posedge clk_i) begin
    if (l_we) begin
      large_mem_q[l_vic_q] <= ev_q;
    end
    large_rd_q <= large_mem_q[cnt_q];
  end

  assign res_o.valid      = res_vld_q;
  assign res_o.is_extreme = res_q.is_extreme;
  assign res_o.small_hit  = res_q.small_hit;
  assign res_o.large_hit  = res_q.large_hit;
  assign res_o.rejected   = res_q.rejected;

endmodule

`default_nettype wire

FILE: rtl/extreme_event_tracker.sv
// ============================================================================
// extreme_event_tracker: running K smallest / K largest event sizes
// Keeps the SET_SIZE smallest and largest event sizes seen and reports,
// per event, whether it entered either set.
// ============================================================================
// Each beat on evt_i carries one unsigned Q16.16 event size; each beat on
// res_o reports whether that event replaced a member of the small set, of
// the large set, or of either, and whether it was rejected because its size
// (after trimming to VALUE_BITS) is zero, in which case nothing changes.
// Empty slots count as +infinity in the small set and as -infinity in the
// large set, so the first SET_SIZE nonzero events always enter both; among
// tied victims the lowest slot is replaced. A nonzero event passes the
// back part in order: it is taken from the queue, both value stores are
// scanned through their single read port, one slot per cycle, and the
// victims are written while the result register is loaded. A rejected
// event skips the scan. A two-entry queue in front lets the source hand
// over further events while one is being scanned, and the result
// register holds a finished beat while the next event is taken.
// The value stores need no clearing after reset: per-slot fill flags are
// cleared at once and a value is only compared where its flag is set.
`default_nettype none

module extreme_event_tracker #(
  parameter int SET_SIZE   = eet_pkg::DefSetSize,
  parameter int VALUE_BITS = eet_pkg::DefValueBits
) (
  input  wire       clk_i,
  input  wire       rst_ni,
  eet_evt_if.sink   evt_i,
  eet_res_if.source res_o
);
  import eet_pkg::*;

  // Queue head handed from the front part to the back part.
  logic                  deq_valid;
  logic                  deq_ready;
  logic [VALUE_BITS-1:0] deq_value;
  logic                  deq_rejected;

  // Front part: accept, trim, classify and queue.
  eet_front #(
    .VALUE_BITS (VALUE_BITS)
  ) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .evt_i          (evt_i),
    .deq_valid_o    (deq_valid),
    .deq_ready_i    (deq_ready),
    .deq_value_o    (deq_value),
    .deq_rejected_o (deq_rejected)
  );

  // Back part: scan both sets, replace victims, register the result.
  eet_back #(
    .SET_SIZE   (SET_SIZE),
    .VALUE_BITS (VALUE_BITS)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .deq_valid_i    (deq_valid),
    .deq_ready_o    (deq_ready),
    .deq_value_i    (deq_value),
    .deq_rejected_i (deq_rejected),
    .res_o          (res_o)
  );

endmodule

`default_nettype wire

FILE: rtl/eet_checker.sv
// ============================================================================
// eet_checker: port-level checks of the extreme event tracker
// Tracks beats in flight and checks result consistency at the ports.
// ============================================================================
`default_nettype none

module eet_checker (
  input wire clk_i,
  input wire rst_ni,
  input wire in_valid_i,
  input wire in_ready_i,
  input wire out_valid_i,
  input wire out_ready_i,
  input wire is_extreme_i,
  input wire small_hit_i,
  input wire large_hit_i,
  input wire rejected_i
);

  logic [3:0] inflight_q;
  logic       in_fire;
  logic       out_fire;

  assign in_fire  = in_valid_i && in_ready_i;
  assign out_fire = out_valid_i && out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inflight_q <= 4'd0;
    end else if (in_fire && !out_fire) begin
      inflight_q <= inflight_q + 4'd1;
    end else if (out_fire && !in_fire) begin
      inflight_q <= inflight_q - 4'd1;
    end
  end

  // A result beat always belongs to an event taken earlier.
  a_no_orphan_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (inflight_q != 4'd0))
    else $error("result beat without an outstanding event");

  // Queue, scan stage and result register hold at most four events.
  a_inflight_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    inflight_q <= 4'd4)
    else $error("more events in flight than the design can hold");

  a_extreme_is_or: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (is_extreme_i == (small_hit_i || large_hit_i)))
    else $error("is_extreme differs from the hit flags");

  a_rejected_no_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && rejected_i) |-> (!small_hit_i && !large_hit_i))
    else $error("rejected event reported a hit");

  a_result_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |=> (out_valid_i && $stable(is_extreme_i)
      && $stable(small_hit_i) && $stable(large_hit_i) && $stable(rejected_i)))
    else $error("stalled result beat changed");

endmodule

bind extreme_event_tracker eet_checker u_eet_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (evt_i.valid),
  .in_ready_i   (evt_i.ready),
  .out_valid_i  (res_o.valid),
  .out_ready_i  (res_o.ready),
  .is_extreme_i (res_o.is_extreme),
  .small_hit_i  (res_o.small_hit),
  .large_hit_i  (res_o.large_hit),
  .rejected_i   (res_o.rejected)
);

`default_nettype wire
